// ===== sv/cfst_pkg.sv =====
// shared types and constants of the coalescing serial transmitter
`timescale 1ns / 1ps
package cfst_pkg;

   localparam int CMD_W   = 3;
   localparam int BYTE_W  = 8;
   localparam int TICK_W  = 16;
   localparam int LEVEL_W = 6;
   localparam int CSR_IDX_W = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK     = 3'd0,
      CMD_PUSH     = 3'd1,
      CMD_PAIR     = 3'd2,
      CMD_LATEST   = 3'd3,
      CMD_ENVELOPE = 3'd4,
      CMD_DISCARD  = 3'd5,
      CMD_TAKE_OVF = 3'd6
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SETUP  = 2'd0,
      REG_BIT    = 2'd1,
      REG_GAP    = 2'd2,
      REG_INVERT = 2'd3
   } csr_reg_type;

   localparam logic [TICK_W-1:0] SETUP_RESET = 16'd2;
   localparam logic [TICK_W-1:0] BIT_RESET   = 16'd10;
   localparam logic [TICK_W-1:0] GAP_RESET   = 16'd50;

   localparam logic [BYTE_W-1:0] GROUP_MASK  = 8'hE0;
   localparam logic [BYTE_W-1:0] GROUP_LIMIT = 8'hC0;
   localparam logic [BYTE_W-1:0] VALUE_MASK  = 8'hF0;
   localparam logic [2:0]        TOP_BIT     = 3'd7;

endpackage

// ===== sv/cfst_req_if.sv =====
// command channel interface
`timescale 1ns / 1ps
interface cfst_req_if
   import cfst_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [BYTE_W-1:0] first_byte;
   logic [BYTE_W-1:0] second_byte;

   modport source (output valid, output cmd, output first_byte, output second_byte,
                   input ready);
   modport sink (input valid, input cmd, input first_byte, input second_byte,
                 output ready);
endinterface

// ===== sv/cfst_rsp_if.sv =====
// result channel interface
`timescale 1ns / 1ps
interface cfst_rsp_if
   import cfst_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic               accepted;
   logic               overflow_seen;
   logic               data_line;
   logic               clock_line;
   logic [LEVEL_W-1:0] queue_level;

   modport source (output valid, output accepted, output overflow_seen, output data_line,
                   output clock_line, output queue_level, input ready);
   modport sink (input valid, input accepted, input overflow_seen, input data_line,
                 input clock_line, input queue_level, output ready);
endinterface

// ===== sv/coalescing_fifo_serial_transmitter.sv =====
// byte queue with coalescing pushes feeding an msb-first clocked serial sender
//
// req_ch carries one command word (tick, push, push pair, push latest, envelope,
// discard, take overflow); rsp_ch returns exactly one result word per command.
// csr_we / csr_index / csr_wdata write setup, bit and gap tick counts and the
// output inversion bit; write only while no command is in flight.
// Discard, take overflow and plain ticks go from the execute state straight to
// the result; a tick that loads the next byte passes the load state, a push the
// push state, a push pair the push and second-byte states. Push latest (for a
// byte whose group is below GROUP_LIMIT) and envelope walk the queue through the
// single read port of the byte store, one entry a cycle. One command is worked on
// at a time; req_ch.ready is high while the sequencer waits for a command.
// The result sits in an output register, so the next command is taken while it
// waits; a stalled receiver holds the sequencer only once a second result is done.
// Reset (synchronous) empties the queue, clears the overflow flag, loads the
// default timing and puts the sender in its inter-byte gap; no clearing pass.
`timescale 1ns / 1ps
module coalescing_fifo_serial_transmitter
   import cfst_pkg::*;
#(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   cfst_req_if.sink             req_ch,
   cfst_rsp_if.source           rsp_ch,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TICK_W-1:0]    csr_wdata
);

   localparam int PW    = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = PW + 1;
   localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_EXEC   = 8'b0000_0010,
      ST_LOAD   = 8'b0000_0100,
      ST_LATEST = 8'b0000_1000,
      ST_ENV    = 8'b0001_0000,
      ST_PUSH   = 8'b0010_0000,
      ST_PAIR2  = 8'b0100_0000,
      ST_DONE   = 8'b1000_0000
   } seq_state_type;

   typedef enum logic [3:0] {
      PH_IDLE  = 4'b0001,
      PH_SETUP = 4'b0010,
      PH_HOLD  = 4'b0100,
      PH_GAP   = 4'b1000
   } tx_phase_type;

   function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
      ptr_next = (p == PTR_LAST) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PW-1:0] ptr_prev(input logic [PW-1:0] p);
      ptr_prev = (p == '0) ? PTR_LAST : p - 1'b1;
   endfunction

   // byte store
   logic [BYTE_W-1:0] store_ff [QUEUE_DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;
   logic [PW-1:0]     rd_addr;
   logic              mem_we;
   logic [PW-1:0]     mem_waddr;
   logic [BYTE_W-1:0] mem_wdata;

   // control state
   seq_state_type      state_ff, state_in;
   tx_phase_type       phase_ff, phase_in;
   logic [PW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [PW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic               ovf_ff, ovf_in;
   logic [BYTE_W-1:0]  shift_ff, shift_in;
   logic [2:0]         bitpos_ff, bitpos_in;
   logic               clk_lvl_ff, clk_lvl_in;
   logic               dat_lvl_ff, dat_lvl_in;
   logic [TICK_W-1:0]  wait_ff, wait_in;
   logic [TICK_W-1:0]  setup_ff, bit_ff, gap_ff;
   logic               inv_ff;
   logic               acc_ff, acc_in;
   logic               seen_ff, seen_in;
   logic [PW-1:0]      scan_addr_ff, scan_addr_in;
   logic [PW-1:0]      left_ff, left_in;
   logic [PW-1:0]      cmp_addr_ff, cmp_addr_in;
   logic               cmp_valid_ff, cmp_valid_in;
   logic [BYTE_W-1:0]  prev_byte_ff, prev_byte_in;
   logic               prev_ok_ff, prev_ok_in;
   logic               found_ff, found_in;
   logic [PW-1:0]      slot_ff, slot_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // command word and result payload
   cmd_type            cmd_ff;
   logic [BYTE_W-1:0]  b1_ff, b2_ff;
   logic               out_acc_ff, out_seen_ff, out_data_ff, out_clk_ff;
   logic [LEVEL_W-1:0] out_level_ff;

   logic [PW-1:0]      used;
   logic [PW+5:0]      used_ext;
   logic               room1, room2;
   logic [TICK_W-1:0]  wait_dec;
   logic [TICK_W-1:0]  hold_ticks;
   logic               req_take;
   logic               out_load;

   assign used = (wr_ptr_ff >= rd_ptr_ff) ? (wr_ptr_ff - rd_ptr_ff)
               : PW'(CNT_W'(wr_ptr_ff) + CNT_W'(QUEUE_DEPTH) - CNT_W'(rd_ptr_ff));
   assign used_ext   = (PW + 6)'(used);
   assign room1      = used < PW'(QUEUE_DEPTH - 1);
   assign room2      = used < PW'(QUEUE_DEPTH - 2);
   assign wait_dec   = (wait_ff != '0) ? wait_ff - 1'b1 : '0;
   assign hold_ticks = (bit_ff > setup_ff) ? bit_ff - setup_ff : '0;
   assign req_take   = req_ch.valid && (state_ff == ST_IDLE);
   assign out_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ch.ready);

   assign req_ch.ready         = (state_ff == ST_IDLE);
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.accepted      = out_acc_ff;
   assign rsp_ch.overflow_seen = out_seen_ff;
   assign rsp_ch.data_line     = out_data_ff;
   assign rsp_ch.clock_line    = out_clk_ff;
   assign rsp_ch.queue_level   = out_level_ff;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      rd_ptr_in    = rd_ptr_ff;
      wr_ptr_in    = wr_ptr_ff;
      ovf_in       = ovf_ff;
      shift_in     = shift_ff;
      bitpos_in    = bitpos_ff;
      clk_lvl_in   = clk_lvl_ff;
      dat_lvl_in   = dat_lvl_ff;
      wait_in      = wait_ff;
      acc_in       = acc_ff;
      seen_in      = seen_ff;
      scan_addr_in = scan_addr_ff;
      left_in      = left_ff;
      cmp_addr_in  = cmp_addr_ff;
      cmp_valid_in = 1'b0;
      prev_byte_in = prev_byte_ff;
      prev_ok_in   = prev_ok_ff;
      found_in     = found_ff;
      slot_in      = slot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rd_addr      = scan_addr_ff;
      mem_we       = 1'b0;
      mem_waddr    = wr_ptr_ff;
      mem_wdata    = b1_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               acc_in   = 1'b0;
               seen_in  = 1'b0;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            rd_addr  = rd_ptr_ff;
            state_in = ST_DONE;
            case (cmd_ff)
               CMD_TICK: begin
                  wait_in = wait_dec;
                  if (wait_dec == '0) begin
                     case (phase_ff)
                        PH_IDLE, PH_GAP: begin
                           if (rd_ptr_ff == wr_ptr_ff) begin
                              phase_in = PH_IDLE;
                              wait_in  = gap_ff;
                           end else begin
                              rd_ptr_in = ptr_next(rd_ptr_ff);
                              state_in  = ST_LOAD;
                           end
                        end
                        PH_SETUP: begin
                           clk_lvl_in = !clk_lvl_ff;
                           phase_in   = PH_HOLD;
                           wait_in    = hold_ticks;
                        end
                        PH_HOLD: begin
                           if (bitpos_ff == '0) begin
                              phase_in = PH_GAP;
                              wait_in  = gap_ff;
                           end else begin
                              bitpos_in  = bitpos_ff - 1'b1;
                              dat_lvl_in = shift_ff[bitpos_ff - 1'b1];
                              phase_in   = PH_SETUP;
                              wait_in    = setup_ff;
                           end
                        end
                        default: ;
                     endcase
                  end
               end
               CMD_PUSH, CMD_PAIR: state_in = ST_PUSH;
               CMD_LATEST: begin
                  if ((b1_ff & GROUP_MASK) < GROUP_LIMIT) begin
                     scan_addr_in = ptr_prev(wr_ptr_ff);
                     left_in      = used;
                     state_in     = ST_LATEST;
                  end
               end
               CMD_ENVELOPE: begin
                  scan_addr_in = rd_ptr_ff;
                  left_in      = used;
                  prev_ok_in   = 1'b0;
                  found_in     = 1'b0;
                  state_in     = ST_ENV;
               end
               CMD_DISCARD: begin
                  rd_ptr_in = wr_ptr_ff;
                  ovf_in    = 1'b0;
               end
               CMD_TAKE_OVF: begin
                  seen_in = ovf_ff;
                  ovf_in  = 1'b0;
               end
               default: ;
            endcase
         end
         ST_LOAD: begin
            shift_in   = rd_data_ff;
            bitpos_in  = TOP_BIT;
            dat_lvl_in = rd_data_ff[TOP_BIT];
            phase_in   = PH_SETUP;
            wait_in    = setup_ff;
            state_in   = ST_DONE;
         end
         ST_LATEST: begin
            // newest entry first, stop at the first one of the same group
            if (cmp_valid_ff && ((rd_data_ff & GROUP_MASK) == (b1_ff & GROUP_MASK))) begin
               mem_we    = 1'b1;
               mem_waddr = cmp_addr_ff;
               acc_in    = 1'b1;
               state_in  = ST_DONE;
            end else if (left_ff != '0) begin
               cmp_valid_in = 1'b1;
               cmp_addr_in  = scan_addr_ff;
               scan_addr_in = ptr_prev(scan_addr_ff);
               left_in      = left_ff - 1'b1;
            end else if (!cmp_valid_ff) begin
               state_in = ST_PUSH;
            end
         end
         ST_ENV: begin
            // oldest entry first, keep the last select/value pair
            if (cmp_valid_ff) begin
               if (prev_ok_ff && (prev_byte_ff == b1_ff)
                   && ((rd_data_ff & VALUE_MASK) == VALUE_MASK)) begin
                  found_in = 1'b1;
                  slot_in  = cmp_addr_ff;
               end
               prev_byte_in = rd_data_ff;
               prev_ok_in   = 1'b1;
            end
            if (left_ff != '0) begin
               cmp_valid_in = 1'b1;
               cmp_addr_in  = scan_addr_ff;
               scan_addr_in = ptr_next(scan_addr_ff);
               left_in      = left_ff - 1'b1;
            end else if (!cmp_valid_ff) begin
               if (found_ff) begin
                  mem_we    = 1'b1;
                  mem_waddr = slot_ff;
                  mem_wdata = b2_ff;
                  acc_in    = 1'b1;
                  state_in  = ST_DONE;
               end else begin
                  state_in = ST_PUSH;
               end
            end
         end
         ST_PUSH: begin
            if ((cmd_ff == CMD_PAIR) || (cmd_ff == CMD_ENVELOPE)) begin
               if (room2) begin
                  mem_we    = 1'b1;
                  wr_ptr_in = ptr_next(wr_ptr_ff);
                  state_in  = ST_PAIR2;
               end else begin
                  ovf_in   = 1'b1;
                  state_in = ST_DONE;
               end
            end else begin
               if (room1) begin
                  mem_we    = 1'b1;
                  wr_ptr_in = ptr_next(wr_ptr_ff);
                  acc_in    = 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               state_in = ST_DONE;
            end
         end
         ST_PAIR2: begin
            mem_we    = 1'b1;
            mem_wdata = b2_ff;
            wr_ptr_in = ptr_next(wr_ptr_ff);
            acc_in    = 1'b1;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_GAP;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         ovf_ff       <= 1'b0;
         shift_ff     <= '0;
         bitpos_ff    <= TOP_BIT;
         clk_lvl_ff   <= 1'b0;
         dat_lvl_ff   <= 1'b0;
         wait_ff      <= GAP_RESET;
         setup_ff     <= SETUP_RESET;
         bit_ff       <= BIT_RESET;
         gap_ff       <= GAP_RESET;
         inv_ff       <= 1'b0;
         acc_ff       <= 1'b0;
         seen_ff      <= 1'b0;
         left_ff      <= '0;
         cmp_valid_ff <= 1'b0;
         prev_ok_ff   <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         ovf_ff       <= ovf_in;
         shift_ff     <= shift_in;
         bitpos_ff    <= bitpos_in;
         clk_lvl_ff   <= clk_lvl_in;
         dat_lvl_ff   <= dat_lvl_in;
         wait_ff      <= wait_in;
         acc_ff       <= acc_in;
         seen_ff      <= seen_in;
         left_ff      <= left_in;
         cmp_valid_ff <= cmp_valid_in;
         prev_ok_ff   <= prev_ok_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_reg_type'(csr_index))
               REG_SETUP:  setup_ff <= csr_wdata;
               REG_BIT:    bit_ff   <= csr_wdata;
               REG_GAP:    gap_ff   <= csr_wdata;
               REG_INVERT: inv_ff   <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_addr_ff <= scan_addr_in;
      cmp_addr_ff  <= cmp_addr_in;
      prev_byte_ff <= prev_byte_in;
      slot_ff      <= slot_in;
      if (req_take) begin
         cmd_ff <= cmd_type'(req_ch.cmd);
         b1_ff  <= req_ch.first_byte;
         b2_ff  <= req_ch.second_byte;
      end
      if (out_load) begin
         out_acc_ff   <= acc_ff;
         out_seen_ff  <= seen_ff;
         out_data_ff  <= dat_lvl_ff ^ inv_ff;
         out_clk_ff   <= clk_lvl_ff ^ inv_ff;
         out_level_ff <= used_ext[LEVEL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_ff[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff <= PTR_LAST) && (rd_ptr_ff <= PTR_LAST))
      else $error("queue pointer beyond queue depth");

   a_wr_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (wr_ptr_ff != $past(wr_ptr_ff)))
      |-> (wr_ptr_ff == ptr_next($past(wr_ptr_ff))))
      else $error("write pointer moved by more than one entry");

   a_ovf_cause: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(ovf_ff))
      |-> ((cmd_ff == CMD_PUSH) || (cmd_ff == CMD_PAIR)
           || (cmd_ff == CMD_LATEST) || (cmd_ff == CMD_ENVELOPE)))
      else $error("overflow flag set by a command that does not enqueue");

   a_cmp_in_scan: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && cmp_valid_ff)
      |-> ($past(state_ff) == ST_LATEST || $past(state_ff) == ST_ENV))
      else $error("compare stage active outside a queue walk");

endmodule
